>>> sv/mtseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtseq_pkg
// Shared types and constants of the melody tone sequencer.
// ----------------------------------------------------------------------------
package mtseq_pkg;

  // Build defaults
  localparam int SONG_SLOTS_DEFAULT = 16;
  localparam int CLOCK_HZ_DEFAULT   = 16000000;

  // Field widths
  localparam int KEY_W    = 7;
  localparam int COLOUR_W = 3;
  localparam int LENGTH_W = 16;
  localparam int GAP_W    = 10;
  localparam int POS_W    = 5;
  localparam int PERIOD_W = 16;
  localparam int CMP_W    = 15;
  localparam int KEYS     = 1 << KEY_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH = 2'd1;
  localparam logic [GAP_W-1:0]     GAP_MS_RESET    = 10'd30;

  // Request opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  // Play mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PLAY  = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  // One stored song step
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [COLOUR_W-1:0] colour;
    logic [LENGTH_W-1:0] length;
  } step_t;

  localparam int STEP_W = $bits(step_t);

  // 2^(r/12) scaled by 1e9, rounded
  localparam logic [63:0] SEMITONE_SCALE [12] = '{
    64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
    64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
    64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
  };

  localparam logic [63:0] A4_SCALED = 64'd440000000000;

endpackage

`default_nettype wire

>>> sv/melody_tone_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// melody_tone_sequencer_core
// Event-driven song player: ticks, buttons and step writes drive PWM tone
// and LED settings, one result per request.
// ----------------------------------------------------------------------------
// Every request (1 ms tick, button event or song step write) is taken while
// in_stall is low and its result appears in the output register on the next
// cycle; a new request can be taken every cycle as long as the result side
// keeps up. The song steps live in a synchronous RAM that is read every
// cycle at the next play position, so the step to start is already waiting
// when the next request arrives; a write to that same step in the previous
// or the current cycle is forwarded. The PWM load value comes from a
// constant key table built from CLOCK_HZ. Configuration writes are always
// ready and take effect on the next request.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_core #(
  parameter int SONG_SLOTS = mtseq_pkg::SONG_SLOTS_DEFAULT,
  parameter int CLOCK_HZ   = mtseq_pkg::CLOCK_HZ_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,

  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mtseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mtseq_pkg::CFG_DATA_W-1:0]  cfg_data,

  // Request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        opcode,
  input  wire logic                              sw1_pressed,
  input  wire logic                              sw2_pressed,
  input  wire logic [3:0]                        slot,
  input  wire logic [mtseq_pkg::KEY_W-1:0]       note_number,
  input  wire logic [mtseq_pkg::COLOUR_W-1:0]    led_bits,
  input  wire logic [mtseq_pkg::LENGTH_W-1:0]    duration_ms,

  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             play_mode,
  output logic                                   tone_on,
  output logic [mtseq_pkg::PERIOD_W-1:0]         tone_period,
  output logic [mtseq_pkg::CMP_W-1:0]            tone_compare,
  output logic [mtseq_pkg::COLOUR_W-1:0]         led_colour,
  output logic [mtseq_pkg::POS_W-1:0]            position,
  output logic                                   note_sounding
);

  localparam int ADDR_W   = (SONG_SLOTS > 1) ? $clog2(SONG_SLOTS) : 1;
  localparam int SLOT_CAP = (SONG_SLOTS < 31) ? SONG_SLOTS : 31;
  localparam logic [mtseq_pkg::POS_W-1:0] CAP = mtseq_pkg::POS_W'(SLOT_CAP);

  // Configuration registers
  logic [mtseq_pkg::GAP_W-1:0] gap_ms;
  logic [mtseq_pkg::POS_W-1:0] song_length;

  // Player state
  mtseq_pkg::mode_t               mode, mode_next;
  logic [mtseq_pkg::POS_W-1:0]    step_index, step_index_next;
  logic [mtseq_pkg::LENGTH_W-1:0] note_countdown, note_countdown_next;
  logic                           note_live, note_live_next;
  logic [mtseq_pkg::GAP_W-1:0]    gap_countdown, gap_countdown_next;
  logic                           hold_flag, hold_flag_next;
  logic [mtseq_pkg::PERIOD_W-1:0] period_reg, period_reg_next;
  logic                           tone_enable, tone_enable_next;
  logic [mtseq_pkg::COLOUR_W-1:0] led_reg, led_reg_next;

  // Song store access
  logic                  accept;
  logic                  slot_ok;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  mtseq_pkg::step_t      ram_wdata;
  mtseq_pkg::step_t      ram_rdata;
  logic                  byp_hit;
  mtseq_pkg::step_t      byp_data;
  mtseq_pkg::step_t      cur_step;
  logic [mtseq_pkg::POS_W-1:0]    limit;
  logic [mtseq_pkg::PERIOD_W-1:0] rom_period;
  logic [mtseq_pkg::LENGTH_W-1:0] gap_wide;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms      <= mtseq_pkg::GAP_MS_RESET;
      song_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtseq_pkg::CFG_GAP_MS:      gap_ms      <= cfg_data;
        mtseq_pkg::CFG_SONG_LENGTH: song_length <= cfg_data[mtseq_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Song step writes
  assign slot_ok   = 32'(slot) < 32'(SONG_SLOTS);
  assign ram_we    = accept && (opcode == mtseq_pkg::OP_WRITE) && slot_ok;
  assign ram_waddr = ADDR_W'(slot);
  assign ram_wdata = '{key: note_number, colour: led_bits, length: duration_ms};
  assign ram_raddr = ADDR_W'(step_index_next);

  mtseq_ram #(
    .WIDTH (mtseq_pkg::STEP_W),
    .DEPTH (SONG_SLOTS)
  ) u_song_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Catch a write that landed on the address being read
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= ram_we && (ram_waddr == ram_raddr);
    end
    byp_data <= ram_wdata;
  end

  // Step at the current position, newest write first
  always_comb begin
    if (ram_we && (ram_waddr == ADDR_W'(step_index))) begin
      cur_step = ram_wdata;
    end else if (byp_hit) begin
      cur_step = byp_data;
    end else begin
      cur_step = ram_rdata;
    end
  end

  mtseq_period_rom #(
    .CLOCK_HZ (CLOCK_HZ)
  ) u_period_rom (
    .key    (cur_step.key),
    .period (rom_period)
  );

  assign limit    = (song_length < CAP) ? song_length : CAP;
  assign gap_wide = mtseq_pkg::LENGTH_W'(gap_ms);

  // Event action followed by mode settling
  always_comb begin
    mode_next           = mode;
    step_index_next     = step_index;
    note_countdown_next = note_countdown;
    note_live_next      = note_live;
    gap_countdown_next  = gap_countdown;
    hold_flag_next      = hold_flag;
    period_reg_next     = period_reg;
    tone_enable_next    = tone_enable;
    led_reg_next        = led_reg;

    if (accept) begin
      // tick: note timer, then gap timer
      if ((opcode == mtseq_pkg::OP_TICK) && !hold_flag) begin
        if (note_live) begin
          if (note_countdown != '0) begin
            note_countdown_next = note_countdown - 1'b1;
          end else begin
            tone_enable_next   = 1'b0;
            note_live_next     = 1'b0;
            gap_countdown_next = gap_ms;
          end
        end else if (gap_countdown != '0) begin
          gap_countdown_next = gap_countdown - 1'b1;
        end
      end

      // buttons: play/pause toggle, then stop
      if (opcode == mtseq_pkg::OP_BUTTON) begin
        if (sw1_pressed) begin
          mode_next = (mode == mtseq_pkg::MODE_PLAY) ? mtseq_pkg::MODE_PAUSE
                                                     : mtseq_pkg::MODE_PLAY;
        end
        if (sw2_pressed) begin
          mode_next = mtseq_pkg::MODE_IDLE;
        end
      end

      // settle
      case (mode_next)
        mtseq_pkg::MODE_IDLE: begin
          tone_enable_next = 1'b0;
          led_reg_next     = '0;
          step_index_next  = '0;
        end
        mtseq_pkg::MODE_PLAY: begin
          if (hold_flag_next) begin
            hold_flag_next   = 1'b0;
            tone_enable_next = 1'b1;
          end
          if (!note_live_next && (gap_countdown_next == '0)) begin
            if (step_index >= limit) begin
              mode_next        = mtseq_pkg::MODE_IDLE;
              tone_enable_next = 1'b0;
              led_reg_next     = '0;
              step_index_next  = '0;
            end else begin
              period_reg_next     = rom_period;
              led_reg_next        = cur_step.colour;
              tone_enable_next    = 1'b1;
              note_countdown_next = (cur_step.length > gap_wide) ?
                                    cur_step.length - gap_wide : cur_step.length;
              note_live_next      = 1'b1;
              step_index_next     = step_index + 1'b1;
            end
          end
        end
        default: begin
          tone_enable_next = 1'b0;
          hold_flag_next   = 1'b1;
        end
      endcase
    end
  end

  // Player state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= mtseq_pkg::MODE_IDLE;
      step_index     <= '0;
      note_countdown <= '0;
      note_live      <= 1'b0;
      gap_countdown  <= '0;
      hold_flag      <= 1'b0;
      period_reg     <= '0;
      tone_enable    <= 1'b0;
      led_reg        <= '0;
    end else begin
      mode           <= mode_next;
      step_index     <= step_index_next;
      note_countdown <= note_countdown_next;
      note_live      <= note_live_next;
      gap_countdown  <= gap_countdown_next;
      hold_flag      <= hold_flag_next;
      period_reg     <= period_reg_next;
      tone_enable    <= tone_enable_next;
      led_reg        <= led_reg_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      play_mode     <= mode_next;
      tone_on       <= tone_enable_next;
      tone_period   <= period_reg_next;
      tone_compare  <= period_reg_next[mtseq_pkg::PERIOD_W-1:1];
      led_colour    <= led_reg_next;
      position      <= step_index_next;
      note_sounding <= note_live_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/mtseq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtseq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/mtseq_period_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtseq_period_rom
// Key number to PWM load value, built at elaboration:
// floor(CLOCK_HZ * 2^((49-n)/12) / 440) - 1, clamped to 2..65535.
// ----------------------------------------------------------------------------
module mtseq_period_rom #(
  parameter int CLOCK_HZ = mtseq_pkg::CLOCK_HZ_DEFAULT
) (
  input  wire logic [mtseq_pkg::KEY_W-1:0]    key,
  output logic      [mtseq_pkg::PERIOD_W-1:0] period
);

  logic [mtseq_pkg::PERIOD_W-1:0] rom [mtseq_pkg::KEYS];

  // One constant entry per key; octave split so the product stays exact
  for (genvar k = 0; k < mtseq_pkg::KEYS; k++) begin : g_entry
    localparam int          SHIFTED = 133 - k;
    localparam int          OCTAVE  = SHIFTED / 12 - 7;
    localparam int          SEMI    = SHIFTED % 12;
    localparam int          UP      = (OCTAVE >= 0) ? OCTAVE : 0;
    localparam int          DOWN    = (OCTAVE < 0) ? -OCTAVE : 0;
    localparam logic [63:0] NUM     =
      (64'(CLOCK_HZ) * mtseq_pkg::SEMITONE_SCALE[SEMI]) << UP;
    localparam logic [63:0] DEN     = mtseq_pkg::A4_SCALED << DOWN;
    localparam logic [63:0] QUOT    = NUM / DEN;
    localparam logic [63:0] LOAD    = (QUOT < 64'd3) ? 64'd2 :
                                      (QUOT > 64'd65536) ? 64'd65535 :
                                      QUOT - 64'd1;
    assign rom[k] = LOAD[mtseq_pkg::PERIOD_W-1:0];
  end

  assign period = rom[key];

endmodule

`default_nettype wire

>>> sv/mtseq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtseq_checker
// Port-level checks of the melody tone sequencer results.
// ----------------------------------------------------------------------------
module mtseq_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [1:0]                        play_mode,
  input wire logic                              tone_on,
  input wire logic [mtseq_pkg::PERIOD_W-1:0]    tone_period,
  input wire logic [mtseq_pkg::CMP_W-1:0]       tone_compare,
  input wire logic [mtseq_pkg::COLOUR_W-1:0]    led_colour,
  input wire logic [mtseq_pkg::POS_W-1:0]       position
);

  // Tone sounds only while playing
  a_tone_only_in_play: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tone_on) |-> (play_mode == mtseq_pkg::MODE_PLAY))
    else $error("tone enabled outside play mode");

  // Idle clears position and LEDs
  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (play_mode == mtseq_pkg::MODE_IDLE)) |->
      ((position == '0) && (led_colour == '0)))
    else $error("idle result with position or LEDs set");

  // Compare tracks the period
  a_compare_half: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tone_compare == tone_period[mtseq_pkg::PERIOD_W-1:1]))
    else $error("compare is not half the period");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(play_mode) && $stable(tone_on) && $stable(tone_period)
       && $stable(led_colour) && $stable(position)))
    else $error("stalled result changed");

endmodule

bind melody_tone_sequencer_core mtseq_checker u_mtseq_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for melody_tone_sequencer_core. An in-bench model of the
// player tracks mode, timers, hold and PWM/LED state and predicts one result
// per accepted request. Directed tests cover song load, buttons, pause/stop,
// end of song and a long gap. Random phases mix ticks, buttons and step writes
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import mtseq_pkg::*;

  localparam logic [1:0] OP_NOP         = 2'd3;   // unused opcode
  localparam int         HOLDOFF_CYCLES = 40;
  localparam int         PHASES         = 8;
  localparam int         PHASE_ITEMS    = 120;

  // 2^(r/12) scaled by 1e9, rounded
  localparam logic [63:0] SEMI_X1E9 [12] = '{
    64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
    64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
    64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
  };

  typedef struct packed {
    logic [1:0]          op;
    logic                sw1;
    logic                sw2;
    logic [3:0]          slot;
    logic [KEY_W-1:0]    key;
    logic [COLOUR_W-1:0] colour;
    logic [LENGTH_W-1:0] dur;
  } song_req_t;

  typedef struct packed {
    mode_t               mode;
    logic                tone;
    logic [PERIOD_W-1:0] period;
    logic [CMP_W-1:0]    cmp;
    logic [COLOUR_W-1:0] led;
    logic [POS_W-1:0]    pos;
    logic                sounding;
  } tone_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          opcode = OP_TICK;
  logic                sw1_pressed = 1'b0;
  logic                sw2_pressed = 1'b0;
  logic [3:0]          slot = '0;
  logic [KEY_W-1:0]    note_number = '0;
  logic [COLOUR_W-1:0] led_bits = '0;
  logic [LENGTH_W-1:0] duration_ms = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          play_mode;
  logic                tone_on;
  logic [PERIOD_W-1:0] tone_period;
  logic [CMP_W-1:0]    tone_compare;
  logic [COLOUR_W-1:0] led_colour;
  logic [POS_W-1:0]    position;
  logic                note_sounding;

  melody_tone_sequencer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .sw1_pressed  (sw1_pressed),
    .sw2_pressed  (sw2_pressed),
    .slot         (slot),
    .note_number  (note_number),
    .led_bits     (led_bits),
    .duration_ms  (duration_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .play_mode    (play_mode),
    .tone_on      (tone_on),
    .tone_period  (tone_period),
    .tone_compare (tone_compare),
    .led_colour   (led_colour),
    .position     (position),
    .note_sounding(note_sounding)
  );

  always #4 clk = ~clk;

  // Player model state
  logic [GAP_W-1:0]    gap_cfg = GAP_MS_RESET;
  logic [POS_W-1:0]    len_cfg = '0;
  mode_t               cur_mode = MODE_IDLE;
  logic [POS_W-1:0]    next_pos = '0;
  logic [LENGTH_W-1:0] note_left = '0;
  logic                note_active = 1'b0;
  logic [GAP_W-1:0]    gap_left = '0;
  logic                paused_hold = 1'b0;
  logic [PERIOD_W-1:0] pwm_period = '0;
  logic [CMP_W-1:0]    pwm_cmp = '0;
  logic                pwm_en = 1'b0;
  logic [COLOUR_W-1:0] led_now = '0;
  step_t               song_steps [16];

  tone_result_t pending_tone_q [$];
  int           fail_count = 0;

  logic stall_rand_en = 1'b0;
  bit   send_rand_en = 1'b0;
  bit   holdoff_req = 1'b0;
  bit   holdoff_ack = 1'b0;
  int   holdoff_left = 0;
  int   stall_burst = 0;

  // PWM load for a key number: exact integer form of 16 MHz / f(key) - 1
  function automatic logic [PERIOD_W-1:0] key_period(input logic [KEY_W-1:0] key);
    int unsigned shifted;
    int          octave;
    int unsigned r;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    shifted = 133 - key;
    octave  = int'(shifted / 12) - 7;
    r       = shifted % 12;
    num     = 64'(CLOCK_HZ_DEFAULT) * SEMI_X1E9[r];
    den     = 64'd440000000000;
    if (octave >= 0) num = num << octave;
    else den = den << (-octave);
    q = num / den;
    if (q < 3) return 16'd2;
    if (q > 65536) return 16'hFFFF;
    return 16'(q - 1);
  endfunction

  function automatic void enter_idle();
    pwm_en   = 1'b0;
    led_now  = '0;
    next_pos = '0;
  endfunction

  // Advance the player by one request and return the settled outputs
  function automatic tone_result_t predict_tone(input song_req_t req);
    tone_result_t res;
    logic [POS_W-1:0] lim;
    step_t st;
    case (req.op)
      OP_TICK: begin
        if (!paused_hold) begin
          if (note_active) begin
            if (note_left > 0) note_left--;
            else begin
              pwm_en      = 1'b0;
              note_active = 1'b0;
              gap_left    = gap_cfg;
            end
          end else if (gap_left > 0) begin
            gap_left--;
          end
        end
      end
      OP_BUTTON: begin
        if (req.sw1) cur_mode = (cur_mode == MODE_PLAY) ? MODE_PAUSE : MODE_PLAY;
        if (req.sw2) cur_mode = MODE_IDLE;
      end
      OP_WRITE: begin
        song_steps[req.slot] = '{key: req.key, colour: req.colour, length: req.dur};
      end
      default: ;
    endcase

    // mode settles after every request
    case (cur_mode)
      MODE_IDLE: enter_idle();
      MODE_PLAY: begin
        if (paused_hold) begin
          paused_hold = 1'b0;
          pwm_en      = 1'b1;
        end
        if (!note_active && gap_left == 0) begin
          lim = (len_cfg < 16) ? len_cfg : 5'd16;
          if (next_pos >= lim) begin
            cur_mode = MODE_IDLE;
            enter_idle();
          end else begin
            st          = song_steps[next_pos[3:0]];
            pwm_period  = key_period(st.key);
            pwm_cmp     = pwm_period[PERIOD_W-1:1];
            led_now     = st.colour;
            pwm_en      = 1'b1;
            note_left   = (st.length > gap_cfg) ? st.length - gap_cfg : st.length;
            note_active = 1'b1;
            next_pos++;
          end
        end
      end
      default: begin
        pwm_en      = 1'b0;
        paused_hold = 1'b1;
      end
    endcase

    res.mode     = cur_mode;
    res.tone     = pwm_en;
    res.period   = pwm_period;
    res.cmp      = pwm_cmp;
    res.led      = led_now;
    res.pos      = next_pos;
    res.sounding = note_active;
    return res;
  endfunction

  // Random payload; the caller sets the fields that matter
  function automatic song_req_t make_req(input logic [1:0] op);
    song_req_t req;
    req.op     = op;
    req.sw1    = 1'($urandom);
    req.sw2    = 1'($urandom);
    req.slot   = 4'($urandom);
    req.key    = 7'($urandom);
    req.colour = 3'($urandom);
    req.dur    = 16'($urandom);
    return req;
  endfunction

  function automatic song_req_t write_req(input logic [3:0] s, input logic [KEY_W-1:0] k,
                                          input logic [COLOUR_W-1:0] c,
                                          input logic [LENGTH_W-1:0] d);
    song_req_t req;
    req        = make_req(OP_WRITE);
    req.slot   = s;
    req.key    = k;
    req.colour = c;
    req.dur    = d;
    return req;
  endfunction

  function automatic song_req_t button_req(input logic b1, input logic b2);
    song_req_t req;
    req     = make_req(OP_BUTTON);
    req.sw1 = b1;
    req.sw2 = b2;
    return req;
  endfunction

  // Send one request and record its predicted result once accepted
  task automatic send_req(input song_req_t req);
    int gap_len;
    if (send_rand_en && $urandom_range(0, 7) == 0) begin
      gap_len = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= req.op;
    sw1_pressed <= req.sw1;
    sw2_pressed <= req.sw2;
    slot        <= req.slot;
    note_number <= req.key;
    led_bits    <= req.colour;
    duration_ms <= req.dur;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_tone_q.push_back(predict_tone(req));
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_req(make_req(OP_TICK));
  endtask

  // Stop offering requests until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tone_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_GAP_MS) gap_cfg = val[GAP_W-1:0];
    else if (idx == CFG_SONG_LENGTH) len_cfg = val[POS_W-1:0];
  endtask

  // Mostly well-formed traffic: ticks, play/pause/stop, short steps
  task automatic send_random_item();
    song_req_t req;
    song_req_t big;
    int pick;
    int sel;
    pick = $urandom_range(0, 99);
    req  = make_req(OP_TICK);
    if (pick < 55) begin
      send_req(req);
    end else if (pick < 75) begin
      sel     = $urandom_range(0, 9);
      req.op  = OP_BUTTON;
      req.sw1 = (sel < 7) || (sel == 9);
      req.sw2 = (sel >= 7);
      send_req(req);
    end else if (pick < 90) begin
      req.op  = OP_WRITE;
      req.dur = 16'($urandom_range(0, 25));
      // long step written only while nothing can start, then overwritten
      if (cur_mode != MODE_PLAY && $urandom_range(0, 3) == 0) begin
        big     = req;
        big.dur = 16'($urandom);
        send_req(big);
      end
      send_req(req);
    end else if (pick < 95) begin
      req.op = OP_NOP;
      send_req(req);
    end else begin
      req.op = OP_BUTTON;
      send_req(req);
    end
  endtask

  // Bring timers and hold to rest with the player idle
  task automatic quiesce();
    send_req(button_req(1'b0, 1'b1));
    send_req(button_req(1'b1, 1'b0));
    send_req(button_req(1'b0, 1'b1));
    run_ticks(40);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_config_regs();
    // reset length is zero: play ends at once
    send_req(button_req(1'b1, 1'b0));
    drain();
    write_cfg(CFG_GAP_MS, 10'd2);
    write_cfg(CFG_SONG_LENGTH, 10'd0);
  endtask

  task automatic test_song_load();
    int i;
    send_req(write_req(4'd0, 7'd49, 3'd1, 16'd3));
    send_req(write_req(4'd1, 7'd0, 3'd2, 16'd0));
    send_req(write_req(4'd2, 7'd127, 3'd4, 16'd5));
    send_req(write_req(4'd3, 7'd1, 3'd7, 16'd1));
    for (i = 4; i < 16; i++)
      send_req(write_req(4'(i), 7'(i * 9), 3'(i), 16'(i)));
    // longest step while idle, then back to a short one
    send_req(write_req(4'd15, 7'd126, 3'd0, 16'hFFFF));
    send_req(write_req(4'd15, 7'd100, 3'd6, 16'd15));
  endtask

  task automatic test_buttons();
    send_req(button_req(1'b1, 1'b0));   // play with empty song
    send_req(make_req(OP_NOP));
    send_req(button_req(1'b1, 1'b1));   // stop wins over play
    drain();
    write_cfg(CFG_SONG_LENGTH, 10'd2);
    send_req(button_req(1'b1, 1'b0));   // first step starts
    run_ticks(1);
    send_req(button_req(1'b1, 1'b0));   // pause sets hold
    run_ticks(2);
    send_req(button_req(1'b0, 1'b1));   // stop keeps hold and timers
    run_ticks(1);
    send_req(button_req(1'b1, 1'b0));   // play clears hold, tone back on
    run_ticks(20);                      // rest of song and end of song
  endtask

  task automatic test_backpressure();
    drain();
    send_rand_en = 1'b0;
    holdoff_req <= ~holdoff_req;
    repeat (30) send_random_item();
    drain();
  endtask

  task automatic test_random_phases();
    int k;
    int i;
    for (k = 0; k < PHASES; k++) begin
      drain();
      if (k == 2) write_cfg(CFG_GAP_MS, 10'd0);
      else write_cfg(CFG_GAP_MS, 10'($urandom_range(1, 5)));
      if (k == 0) write_cfg(CFG_SONG_LENGTH, 10'd16);
      else if (k == 1) write_cfg(CFG_SONG_LENGTH, 10'd31);
      else write_cfg(CFG_SONG_LENGTH, 10'($urandom_range(0, 16)));
      send_rand_en  = (k != PHASES - 1) && (k % 3 != 1);
      stall_rand_en <= (k != PHASES - 1) && (k % 3 != 2);
      for (i = 0; i < PHASE_ITEMS; i++) send_random_item();
    end
  endtask

  task automatic test_long_gap();
    quiesce();
    drain();
    write_cfg(CFG_GAP_MS, 10'd1000);
    write_cfg(CFG_SONG_LENGTH, 10'd1);
    send_req(write_req(4'd0, 7'd60, 3'd5, 16'd1003));   // shortened to 3
    send_req(button_req(1'b1, 1'b0));
    run_ticks(30);
    send_req(button_req(1'b0, 1'b1));
  endtask

  // Receiver: random stall bursts plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_burst = 0;
      holdoff_left = 0;
    end else begin
      if (holdoff_req != holdoff_ack) begin
        holdoff_ack  = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (stall_burst > 0) begin
        stall_burst--;
        out_stall <= 1'b1;
      end else if (stall_rand_en && $urandom_range(0, 9) == 0) begin
        stall_burst = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Result checker: oldest prediction against each accepted result
  always @(posedge clk) begin
    tone_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tone_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with no request pending, expected none, actual mode %0h",
                 $time, play_mode);
      end else begin
        want = pending_tone_q.pop_front();
        check_field("play_mode", 16'(want.mode), 16'(play_mode));
        check_field("tone_on", 16'(want.tone), 16'(tone_on));
        check_field("tone_period", want.period, tone_period);
        check_field("tone_compare", 16'(want.cmp), 16'(tone_compare));
        check_field("led_colour", 16'(want.led), 16'(led_colour));
        check_field("position", 16'(want.pos), 16'(position));
        check_field("note_sounding", 16'(want.sounding), 16'(note_sounding));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_rand_en = 1'b1;
    stall_rand_en <= 1'b1;
    test_config_regs();
    test_song_load();
    test_buttons();
    test_backpressure();
    test_random_phases();
    test_long_gap();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("%0t: timeout, %0d results outstanding", $time, pending_tone_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> melody_tone_sequencer_core.f
sv/mtseq_pkg.sv
sv/mtseq_ram.sv
sv/mtseq_period_rom.sv
sv/melody_tone_sequencer_core.sv
sv/mtseq_checker.sv
sim/tb.sv
